// ----- hdl/pmpd_pkg.sv -----
`timescale 1ns / 1ps

package pmpd_pkg;

   // Header byte bit positions
   localparam int unsigned SYNC_POS   = 3;
   localparam int unsigned X_SIGN_POS = 4;
   localparam int unsigned Y_SIGN_POS = 5;
   localparam int unsigned X_OVF_POS  = 6;
   localparam int unsigned Y_OVF_POS  = 7;
   localparam int unsigned LEFT_POS   = 0;
   localparam int unsigned BTN_W      = 3;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COORD_W = 10;
   // signed sum of a coordinate and a 9-bit delta
   localparam int unsigned SUM_W   = COORD_W + 2;

   localparam logic [COORD_W-1:0] X_LIMIT_RESET = COORD_W'(312);
   localparam logic [COORD_W-1:0] Y_LIMIT_RESET = COORD_W'(192);
   localparam logic [COORD_W-1:0] POS_X_RESET   = COORD_W'(160);
   localparam logic [COORD_W-1:0] POS_Y_RESET   = COORD_W'(100);

   // Register file
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_LIMIT = CSR_IDX_W'(1);

   // Position of a byte inside a packet
   typedef enum logic [1:0] {
      IDX_HEADER = 2'd0,
      IDX_X_MOVE = 2'd1,
      IDX_Y_MOVE = 2'd2
   } pmpd_index_type;

   // Assembled packet, valid for one step when complete is set
   typedef struct packed {
      logic              complete;
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_move;
      logic [BYTE_W-1:0] y_move;
   } pmpd_pkt_type;

   // Decoded result word
   typedef struct packed {
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic [BTN_W-1:0]   button_bits;
      logic               left_pressed;
      logic               left_released;
      logic               moved;
   } pmpd_result_type;

endpackage

// ----- hdl/pmpd_if.sv -----
`timescale 1ns / 1ps

// Byte channel from the mouse receiver
interface pmpd_req_if;
   import pmpd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

// Decoded packet channel
interface pmpd_rsp_if;
   import pmpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cursor_x;
   logic [COORD_W-1:0] cursor_y;
   logic [BTN_W-1:0]   button_bits;
   logic               left_pressed;
   logic               left_released;
   logic               moved;

   modport source (output valid, output cursor_x, output cursor_y, output button_bits,
                   output left_pressed, output left_released, output moved, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input button_bits,
                   input left_pressed, input left_released, input moved, output ready);
endinterface

// Register write channel
interface pmpd_csr_if;
   import pmpd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COORD_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/pmpd_assembler.sv -----
`timescale 1ns / 1ps

module pmpd_assembler
   import pmpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] byte_in,
   output pmpd_pkt_type      pkt
);

   pmpd_index_type    index_ff, index_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] x_move_ff, x_move_in;

   // Byte position register
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= IDX_HEADER;
      end else if (step) begin
         index_ff <= index_in;
      end
   end

   // Held packet bytes
   always_ff @(posedge clock) begin
      if (step) begin
         header_ff <= header_in;
         x_move_ff <= x_move_in;
      end
   end

   // Next position and packet completion
   always_comb begin
      index_in     = index_ff;
      header_in    = header_ff;
      x_move_in    = x_move_ff;
      pkt.complete = 1'b0;
      pkt.header   = header_ff;
      pkt.x_move   = x_move_ff;
      pkt.y_move   = byte_in;
      unique case (index_ff)
         IDX_HEADER: begin
            // header without sync is dropped
            if (byte_in[SYNC_POS]) begin
               header_in = byte_in;
               index_in  = IDX_X_MOVE;
            end
         end
         IDX_X_MOVE: begin
            x_move_in = byte_in;
            index_in  = IDX_Y_MOVE;
         end
         default: begin
            pkt.complete = 1'b1;
            index_in     = IDX_HEADER;
         end
      endcase
   end

endmodule

// ----- hdl/pmpd_cursor.sv -----
`timescale 1ns / 1ps

module pmpd_cursor
   import pmpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  pmpd_pkt_type       pkt,
   input  logic [COORD_W-1:0] x_limit,
   input  logic [COORD_W-1:0] y_limit,
   output logic               emit,
   output pmpd_result_type    result
);

   logic [COORD_W-1:0] pos_x_ff, pos_y_ff;
   logic               last_left_ff;
   logic signed [SUM_W-1:0] dx, dy, sum_x, sum_y;
   logic [COORD_W-1:0] new_x, new_y;
   logic               left;

   // Packets with either overflow flag produce nothing
   assign emit = pkt.complete && !pkt.header[X_OVF_POS] && !pkt.header[Y_OVF_POS];

   // Sign-extend the 9-bit deltas, then move and clamp
   always_comb begin
      dx    = $signed({{(SUM_W-BYTE_W){pkt.header[X_SIGN_POS]}}, pkt.x_move});
      dy    = $signed({{(SUM_W-BYTE_W){pkt.header[Y_SIGN_POS]}}, pkt.y_move});
      sum_x = $signed({{(SUM_W-COORD_W){1'b0}}, pos_x_ff}) + dx;
      sum_y = $signed({{(SUM_W-COORD_W){1'b0}}, pos_y_ff}) - dy;
      priority if (sum_x[SUM_W-1]) begin
         new_x = '0;
      end else if (sum_x[SUM_W-2:0] > {1'b0, x_limit}) begin
         new_x = x_limit;
      end else begin
         new_x = sum_x[COORD_W-1:0];
      end
      priority if (sum_y[SUM_W-1]) begin
         new_y = '0;
      end else if (sum_y[SUM_W-2:0] > {1'b0, y_limit}) begin
         new_y = y_limit;
      end else begin
         new_y = sum_y[COORD_W-1:0];
      end
   end

   assign left = pkt.header[LEFT_POS];

   // Result word
   always_comb begin
      result.cursor_x      = new_x;
      result.cursor_y      = new_y;
      result.button_bits   = pkt.header[BTN_W-1:0];
      result.left_pressed  = left && !last_left_ff;
      result.left_released = !left && last_left_ff;
      // a sign flag with a zero byte still means movement
      result.moved         = (pkt.x_move != '0) || pkt.header[X_SIGN_POS] ||
                             (pkt.y_move != '0) || pkt.header[Y_SIGN_POS];
   end

   // Cursor and button history
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= POS_X_RESET;
         pos_y_ff     <= POS_Y_RESET;
         last_left_ff <= 1'b0;
      end else if (step && emit) begin
         pos_x_ff     <= new_x;
         pos_y_ff     <= new_y;
         last_left_ff <= left;
      end
   end

endmodule

// ----- hdl/ps2_mouse_packet_decoder.sv -----
`timescale 1ns / 1ps

// PS/2 mouse packet decoder, three-byte protocol.
// req_if carries one raw mouse byte per word. Every third byte after a
// header with the sync bit set completes a packet; a packet without
// either overflow flag yields one word on rsp_if with the clamped cursor
// position, the buttons, left-button press/release pulses and a moved flag.
// csr_if writes x_limit (index 0) and y_limit (index 1); other indexes are
// ignored. It is always ready; write it only while the decoder is idle.
// Timing: an accepted byte sits in an input register and is decoded once the
// output register is free or draining; decoding the third byte of a packet
// puts its result word into the output register. One byte is accepted per
// cycle while rsp_if does not stall, set by the single decode stage between the registers.
// When rsp_if stalls, the output register holds its word and one more byte
// waits in the input register; req_if.ready then drops.
// Reset (synchronous) returns the limits to 312/192, the cursor to 160,100,
// clears the button history and restarts packet alignment at a header.
module ps2_mouse_packet_decoder
   import pmpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pmpd_req_if.sink   req_if,
   pmpd_rsp_if.source rsp_if,
   pmpd_csr_if.sink   csr_if
);

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               out_valid_ff;
   pmpd_result_type    out_word_ff;
   logic [COORD_W-1:0] x_limit_ff, y_limit_ff;
   logic               step;
   logic               emit;
   pmpd_pkt_type       pkt;
   pmpd_result_type    result;

   // Decode moves ahead when the output slot is free or draining
   assign step         = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || step;
   assign csr_if.ready = 1'b1;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.byte_in;
      end
   end

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else if (csr_if.valid) begin
         if (csr_if.index == CSR_X_LIMIT) begin
            x_limit_ff <= csr_if.data;
         end
         if (csr_if.index == CSR_Y_LIMIT) begin
            y_limit_ff <= csr_if.data;
         end
      end
   end

   pmpd_assembler u_assembler (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .pkt     (pkt)
   );

   pmpd_cursor u_cursor (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .pkt     (pkt),
      .x_limit (x_limit_ff),
      .y_limit (y_limit_ff),
      .emit    (emit),
      .result  (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         out_word_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.cursor_x      = out_word_ff.cursor_x;
   assign rsp_if.cursor_y      = out_word_ff.cursor_y;
   assign rsp_if.button_bits   = out_word_ff.button_bits;
   assign rsp_if.left_pressed  = out_word_ff.left_pressed;
   assign rsp_if.left_released = out_word_ff.left_released;
   assign rsp_if.moved         = out_word_ff.moved;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import pmpd_pkg::*;

   // indexes outside the register file, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = '1;
   localparam int unsigned PRESSURE_HOLD = 80;
   localparam int unsigned SETTLE_CYCLES = 6;

   logic clock;
   logic reset;

   pmpd_req_if req_bus ();
   pmpd_rsp_if rsp_bus ();
   pmpd_csr_if csr_bus ();

   ps2_mouse_packet_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // decoder mirror: packet alignment, button history, cursor, limits
   pmpd_index_type       pkt_slot;
   logic [BYTE_W-1:0]    pkt_hdr;
   logic [BYTE_W-1:0]    pkt_xmv;
   logic [BTN_W-1:0]     last_btn;
   logic [COORD_W-1:0]   cur_x;
   logic [COORD_W-1:0]   cur_y;
   logic [COORD_W-1:0]   lim_x;
   logic [COORD_W-1:0]   lim_y;
   pmpd_result_type      cursor_reports [$];
   pmpd_result_type      next_report;
   int unsigned          bytes_taken = 0;
   int unsigned          err_count = 0;

   bit gap_on;
   bit stall_on;
   bit hold_pending;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                     input logic [COORD_W-1:0] hi);
      if (v < 0)
         return '0;
      if (v > $signed({2'b00, hi}))
         return hi;
      return v[COORD_W-1:0];
   endfunction

   // update the mirror with one accepted byte, queue a report on a good packet
   function automatic void decode_mouse_byte(input logic [BYTE_W-1:0] b);
      pmpd_result_type          rep;
      logic [BTN_W-1:0]         btn;
      logic signed [SUM_W-1:0]  dx;
      logic signed [SUM_W-1:0]  dy;
      case (pkt_slot)
         IDX_HEADER: begin
            // header without sync is dropped
            if (b[SYNC_POS]) begin
               pkt_hdr = b;
               pkt_slot = IDX_X_MOVE;
               bytes_taken++;
            end
         end
         IDX_X_MOVE: begin
            pkt_xmv = b;
            pkt_slot = IDX_Y_MOVE;
            bytes_taken++;
         end
         default: begin
            pkt_slot = IDX_HEADER;
            bytes_taken++;
            // overflow packets leave no trace
            if (!pkt_hdr[X_OVF_POS] && !pkt_hdr[Y_OVF_POS]) begin
               btn = pkt_hdr[BTN_W-1:0];
               rep.button_bits = btn;
               rep.left_pressed = btn[LEFT_POS] && !last_btn[LEFT_POS];
               rep.left_released = !btn[LEFT_POS] && last_btn[LEFT_POS];
               last_btn = btn;
               // 9-bit deltas: a set sign with a zero byte is -256
               dx = pkt_hdr[X_SIGN_POS] ? {{(SUM_W-BYTE_W){1'b1}}, pkt_xmv}
                                        : {{(SUM_W-BYTE_W){1'b0}}, pkt_xmv};
               dy = pkt_hdr[Y_SIGN_POS] ? {{(SUM_W-BYTE_W){1'b1}}, b}
                                        : {{(SUM_W-BYTE_W){1'b0}}, b};
               rep.moved = (dx != 0) || (dy != 0);
               // y grows downward
               cur_x = clamp_coord($signed({2'b00, cur_x}) + dx, lim_x);
               cur_y = clamp_coord($signed({2'b00, cur_y}) - dy, lim_y);
               rep.cursor_x = cur_x;
               rep.cursor_y = cur_y;
               cursor_reports.push_back(rep);
            end
         end
      endcase
   endfunction

   function automatic void apply_limit(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [COORD_W-1:0] data);
      if (idx == CSR_X_LIMIT)
         lim_x = data;
      else if (idx == CSR_Y_LIMIT)
         lim_y = data;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] pick_move();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'h01;
         2: return 8'hFF;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cursor_reports.size() == 0) begin
            $error("result word with no report pending");
            err_count++;
         end else begin
            next_report = cursor_reports.pop_front();
            check_field("cursor_x", next_report.cursor_x, rsp_bus.cursor_x);
            check_field("cursor_y", next_report.cursor_y, rsp_bus.cursor_y);
            check_field("button_bits", next_report.button_bits, rsp_bus.button_bits);
            check_field("left_pressed", next_report.left_pressed, rsp_bus.left_pressed);
            check_field("left_released", next_report.left_released, rsp_bus.left_released);
            check_field("moved", next_report.moved, rsp_bus.moved);
         end
      end
   end

   // result side ready: random stall bursts, one long hold on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending <= 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (PRESSURE_HOLD) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // one byte word; valid stays up for a back-to-back follower
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (gap_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_in <= b;
      do @(posedge clock); while (!req_bus.ready);
      decode_mouse_byte(b);
   endtask

   task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] xmv,
                              input logic [BYTE_W-1:0] ymv);
      send_byte(hdr);
      send_byte(xmv);
      send_byte(ymv);
   endtask

   // drop valid, let every pending report come out, then let the pipe settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (cursor_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_limit(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      wait_idle();
      csr_write(CSR_X_LIMIT, x);
      csr_write(CSR_Y_LIMIT, y);
   endtask

   // headers without sync, then left press and release
   task automatic test_sync_and_buttons();
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(8'h09, 8'h00, 8'h00);
      send_packet(8'h0E, 8'h01, 8'h01);
   endtask

   // overflow discards, sign with zero byte, delta extremes
   task automatic test_sign_and_overflow();
      send_packet(8'h4F, 8'h7F, 8'h7F);
      send_packet(8'h88, 8'h10, 8'h10);
      send_packet(8'h18, 8'h00, 8'h00);
      send_packet(8'h29, 8'h00, 8'h00);
      send_packet(8'h08, 8'hFF, 8'h80);
      send_packet(8'h38, 8'hFF, 8'hFF);
   endtask

   // limit extremes, lowered limits and writes to unused indexes
   task automatic test_limit_registers();
      set_limits(10'h3FF, 10'h3FF);
      repeat (4) send_packet(8'h28, 8'hFF, 8'h80);
      set_limits(10'h000, 10'h000);
      send_packet(8'h08, 8'h00, 8'h00);
      wait_idle();
      csr_write(CSR_SPARE_HI, 10'h3FF);
      csr_write(CSR_SPARE_LO, 10'h3FF);
      send_packet(8'h08, 8'h05, 8'h05);
      set_limits(X_LIMIT_RESET, Y_LIMIT_RESET);
   endtask

   // long result stall while bytes keep coming
   task automatic test_backpressure();
      logic [BYTE_W-1:0] hdr;
      wait_idle();
      hold_pending <= 1'b1;
      repeat (2) @(posedge clock);
      repeat (12) begin
         hdr = BYTE_W'($urandom);
         hdr[SYNC_POS] = 1'b1;
         hdr[X_OVF_POS] = 1'b0;
         hdr[Y_OVF_POS] = 1'b0;
         send_packet(hdr, pick_move(), pick_move());
      end
      wait_idle();
   endtask

   // mostly good packets, some noise and cut-short packets
   task automatic test_random_traffic(input int unsigned count);
      int unsigned       start;
      int unsigned       kind;
      logic [BYTE_W-1:0] hdr;
      start = bytes_taken;
      while (bytes_taken - start < count) begin
         kind = $urandom_range(0, 19);
         hdr = BYTE_W'($urandom);
         hdr[SYNC_POS] = 1'b1;
         if ($urandom_range(0, 7) != 0) begin
            hdr[X_OVF_POS] = 1'b0;
            hdr[Y_OVF_POS] = 1'b0;
         end
         if (kind == 0) begin
            send_byte(BYTE_W'($urandom));
         end else if (kind == 1) begin
            hdr[SYNC_POS] = 1'b0;
            send_byte(hdr);
         end else if (kind == 2) begin
            send_byte(hdr);
            send_byte(pick_move());
         end else begin
            send_packet(hdr, pick_move(), pick_move());
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.byte_in <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      hold_pending <= 1'b0;
      stall_on <= 1'b0;
      gap_on = 1'b0;
      pkt_slot = IDX_HEADER;
      pkt_hdr = '0;
      pkt_xmv = '0;
      last_btn = '0;
      cur_x = POS_X_RESET;
      cur_y = POS_Y_RESET;
      lim_x = X_LIMIT_RESET;
      lim_y = Y_LIMIT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_on = 1'b1;
      stall_on <= 1'b1;
      test_sync_and_buttons();
      test_sign_and_overflow();
      test_limit_registers();
      test_backpressure();

      test_random_traffic(400);
      set_limits(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      test_random_traffic(400);
      set_limits(10'($urandom_range(0, 31)), 10'($urandom_range(0, 31)));
      test_random_traffic(400);
      set_limits(10'h3FF, 10'h3FF);
      // last stretch at full rate
      gap_on = 1'b0;
      stall_on <= 1'b0;
      test_random_traffic(400);

      wait_idle();
      repeat (10) @(posedge clock);
      if (err_count == 0 && cursor_reports.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
